// ----- rtl/sst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg: shared types for the sparse slot table
// Operation and status codes, controller states and the occupancy command.
// ----------------------------------------------------------------------------
package sst_pkg;

	typedef enum logic [3:0] {
		OP_ASSIGN  = 4'd0,
		OP_UNSET   = 4'd1,
		OP_PUSH    = 4'd2,
		OP_POP     = 4'd3,
		OP_DEQUEUE = 4'd4,
		OP_READ    = 4'd5,
		OP_FRONT   = 4'd6,
		OP_BACK    = 4'd7,
		OP_FIND    = 4'd8,
		OP_CLEAR   = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FREE  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIND,
		S_RESP
	} state_t;

	// Occupancy bitmap update for one cycle
	typedef struct packed {
		logic wr_en;
		logic wr_bit;
		logic cnt_inc;
		logic cnt_dec;
		logic clear_all;
	} occ_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/sst_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_ram: slot data store
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/sst_occ.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sst_occ: occupancy bitmap, occupied count and two-step priority encoder
// Step one registers the lowest and highest non-empty row of sixteen slots;
// step two encodes the bit inside those rows in the following cycle.
// ----------------------------------------------------------------------------
module sst_occ #(
	parameter int SLOT_COUNT = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              snap,
	input  wire sst_pkg::occ_cmd_t                 cmd,
	input  wire logic [$clog2(SLOT_COUNT)-1:0]     wr_addr,
	input  wire logic [$clog2(SLOT_COUNT)-1:0]     q_addr,
	output logic                                   q_bit,
	output logic      [$clog2(SLOT_COUNT)-1:0]     lo_slot,
	output logic      [$clog2(SLOT_COUNT)-1:0]     hi_slot,
	output logic                                   any,
	output logic      [$clog2(SLOT_COUNT+1)-1:0]   count
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int ROW_W  = 16;
	localparam int ROW_IW = 4;
	localparam int GROUPS = (SLOT_COUNT + ROW_W - 1) / ROW_W;
	localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int MAP_W  = GROUPS * ROW_W;
	localparam int MAP_IW = $clog2(MAP_W);

	logic [MAP_W-1:0]  map_q;
	logic [CNT_W-1:0]  count_q;
	logic [GROUPS-1:0] summary;
	logic [GRP_W-1:0]  grp_lo, grp_hi, grp_lo_q, grp_hi_q;
	logic [ROW_W-1:0]  row_lo, row_hi;
	logic [ROW_IW-1:0] bit_lo, bit_hi;

	always_comb begin
		for (int j = 0; j < GROUPS; j++) begin
			summary[j] = |map_q[j*ROW_W +: ROW_W];
		end
	end

	// Row-level encode, registered on snap
	always_comb begin
		grp_lo = '0;
		grp_hi = '0;
		for (int j = GROUPS - 1; j >= 0; j--) begin
			if (summary[j]) grp_lo = GRP_W'(j);
		end
		for (int j = 0; j < GROUPS; j++) begin
			if (summary[j]) grp_hi = GRP_W'(j);
		end
	end

	assign row_lo = map_q[MAP_IW'({grp_lo_q, {ROW_IW{1'b0}}}) +: ROW_W];
	assign row_hi = map_q[MAP_IW'({grp_hi_q, {ROW_IW{1'b0}}}) +: ROW_W];

	// Bit-level encode within the selected rows
	always_comb begin
		bit_lo = '0;
		bit_hi = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (row_lo[b]) bit_lo = ROW_IW'(b);
		end
		for (int b = 0; b < ROW_W; b++) begin
			if (row_hi[b]) bit_hi = ROW_IW'(b);
		end
	end

	assign lo_slot = IDX_W'({grp_lo_q, bit_lo});
	assign hi_slot = IDX_W'({grp_hi_q, bit_hi});
	assign any     = (count_q != '0);
	assign count   = count_q;
	assign q_bit   = map_q[MAP_IW'(q_addr)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= '0;
			count_q  <= '0;
			grp_lo_q <= '0;
			grp_hi_q <= '0;
		end else begin
			if (cmd.clear_all) begin
				map_q <= '0;
			end else if (cmd.wr_en) begin
				map_q[MAP_IW'(wr_addr)] <= cmd.wr_bit;
			end
			if (cmd.clear_all) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (snap) begin
				grp_lo_q <= grp_lo;
				grp_hi_q <= grp_hi;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sparse_slot_table_with_occupancy.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_slot_table_with_occupancy: slot table with occupancy bitmap
// A table of SLOT_COUNT entries held in a single-port RAM, with an occupancy
// bit per slot and a running count of occupied slots.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. For every operation other than
// find, the cycle of acceptance registers the row stage of the
// lowest/highest priority encoder, the next cycle completes the encode and
// performs at most one RAM access and the bitmap update, and the response is
// loaded into the output register while the next request is taken. Find
// walks the data RAM one slot per cycle through its single port and ends
// early when the key is found. The output register lets a new request be
// accepted while a finished response still waits under stall. No clearing
// pass follows reset: the data of free slots is never returned and clear
// only empties the bitmap and count. value_out carries the low 32 bits of
// the entry; slot_out and occupied_count are the low bits of the slot number
// and count.
// ----------------------------------------------------------------------------
module sparse_slot_table_with_occupancy #(
	parameter int SLOT_COUNT  = 256,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [3:0]  operation,
	input  wire logic [7:0]  slot_index,
	input  wire logic [31:0] value_in,
	// response channel
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [31:0] value_out,
	output logic      [7:0]  slot_out,
	output logic      [1:0]  status,
	output logic      [8:0]  occupied_count
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int PTR_W = $clog2(SLOT_COUNT + 1);

	// Controller state
	sst_pkg::state_t state_q, state_d;

	// Captured request
	logic [3:0]             op_q;
	logic [7:0]             idx_q;
	logic [ENTRY_WIDTH-1:0] val_q;

	// Pending response, waiting for the output register
	logic [7:0]        res_slot_q, res_slot_d;
	sst_pkg::status_t  res_status_q, res_status_d;
	logic              res_rd_q, res_rd_d;
	logic              res_load;

	// Find walk
	logic [PTR_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  cmp_addr_s1;
	logic              find_start, find_step;
	logic              walk_end, hit;

	// Output register
	logic              rsp_valid_q;
	logic [31:0]       value_out_q;
	logic [7:0]        slot_out_q;
	sst_pkg::status_t  status_q;
	logic [8:0]        count_out_q;
	logic              out_free, out_load;

	// Handshake
	logic              req_accept;

	// RAM port
	logic                   ram_en, ram_we;
	logic [IDX_W-1:0]       ram_addr;
	logic [ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;

	// Occupancy unit
	sst_pkg::occ_cmd_t occ_cmd;
	logic [IDX_W-1:0]  occ_wr_addr, occ_q_addr;
	logic              occ_q_bit, occ_any;
	logic [IDX_W-1:0]  occ_lo, occ_hi;
	logic [CNT_W-1:0]  occ_count;

	logic              in_range;
	logic [IDX_W-1:0]  idx_slot;
	logic              full;

	sst_ram #(
		.DEPTH (SLOT_COUNT),
		.WIDTH (ENTRY_WIDTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	sst_occ #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_occ (
		.clk     (clk),
		.arst_n  (arst_n),
		.snap    (req_accept),
		.cmd     (occ_cmd),
		.wr_addr (occ_wr_addr),
		.q_addr  (occ_q_addr),
		.q_bit   (occ_q_bit),
		.lo_slot (occ_lo),
		.hi_slot (occ_hi),
		.any     (occ_any),
		.count   (occ_count)
	);

	// Take a request when idle, or while the finished response moves out
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !((state_q == sst_pkg::S_IDLE) ||
		((state_q == sst_pkg::S_RESP) && out_free));
	assign req_accept = req_valid && !req_stall;

	assign in_range = (32'(idx_q) < 32'(SLOT_COUNT));
	assign idx_slot = IDX_W'(idx_q);
	assign full     = occ_any && (occ_hi == IDX_W'(SLOT_COUNT - 1));
	assign walk_end = (ptr_q == PTR_W'(SLOT_COUNT));
	assign hit      = (ram_rdata == val_q) && occ_q_bit;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sst_pkg::S_IDLE: begin
				if (req_accept) state_d = sst_pkg::S_EXEC;
			end
			sst_pkg::S_EXEC: begin
				state_d = (op_q == sst_pkg::OP_FIND) ? sst_pkg::S_FIND : sst_pkg::S_RESP;
			end
			sst_pkg::S_FIND: begin
				if (res_load) state_d = sst_pkg::S_RESP;
			end
			sst_pkg::S_RESP: begin
				if (out_load) state_d = req_accept ? sst_pkg::S_EXEC : sst_pkg::S_IDLE;
			end
			default: state_d = sst_pkg::S_IDLE;
		endcase
	end

	// Datapath controls
	always_comb begin
		ram_en       = 1'b0;
		ram_we       = 1'b0;
		ram_addr     = '0;
		ram_wdata    = '0;
		occ_cmd      = '0;
		occ_wr_addr  = '0;
		occ_q_addr   = '0;
		res_load     = 1'b0;
		res_slot_d   = '0;
		res_status_d = sst_pkg::ST_OK;
		res_rd_d     = 1'b0;
		find_start   = 1'b0;
		find_step    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			sst_pkg::S_EXEC: begin
				occ_q_addr = idx_slot;
				res_load   = 1'b1;
				case (op_q)
					sst_pkg::OP_ASSIGN: begin
						res_slot_d = idx_q;
						if (!in_range) begin
							res_status_d = sst_pkg::ST_RANGE;
						end else begin
							ram_en          = 1'b1;
							ram_we          = 1'b1;
							ram_addr        = idx_slot;
							ram_wdata       = val_q;
							occ_wr_addr     = idx_slot;
							occ_cmd.wr_en   = 1'b1;
							occ_cmd.wr_bit  = 1'b1;
							occ_cmd.cnt_inc = !occ_q_bit;
						end
					end
					sst_pkg::OP_UNSET, sst_pkg::OP_READ: begin
						res_slot_d = idx_q;
						if (!in_range) begin
							res_status_d = sst_pkg::ST_RANGE;
						end else if (!occ_q_bit) begin
							res_status_d = sst_pkg::ST_FREE;
						end else if (op_q == sst_pkg::OP_READ) begin
							ram_en   = 1'b1;
							ram_addr = idx_slot;
							res_rd_d = 1'b1;
						end else begin
							// zero the entry and free the slot
							ram_en          = 1'b1;
							ram_we          = 1'b1;
							ram_addr        = idx_slot;
							occ_wr_addr     = idx_slot;
							occ_cmd.wr_en   = 1'b1;
							occ_cmd.cnt_dec = 1'b1;
						end
					end
					sst_pkg::OP_PUSH: begin
						if (full) begin
							res_status_d = sst_pkg::ST_RANGE;
						end else begin
							ram_en          = 1'b1;
							ram_we          = 1'b1;
							ram_addr        = occ_any ? occ_hi + IDX_W'(1) : '0;
							ram_wdata       = val_q;
							occ_wr_addr     = ram_addr;
							occ_cmd.wr_en   = 1'b1;
							occ_cmd.wr_bit  = 1'b1;
							occ_cmd.cnt_inc = 1'b1;
							res_slot_d      = 8'(ram_addr);
						end
					end
					sst_pkg::OP_POP, sst_pkg::OP_BACK,
					sst_pkg::OP_DEQUEUE, sst_pkg::OP_FRONT: begin
						if (!occ_any) begin
							res_status_d = sst_pkg::ST_EMPTY;
						end else begin
							ram_en   = 1'b1;
							ram_addr = ((op_q == sst_pkg::OP_POP) || (op_q == sst_pkg::OP_BACK))
								? occ_hi : occ_lo;
							res_rd_d   = 1'b1;
							res_slot_d = 8'(ram_addr);
							if ((op_q == sst_pkg::OP_POP) || (op_q == sst_pkg::OP_DEQUEUE)) begin
								occ_wr_addr     = ram_addr;
								occ_cmd.wr_en   = 1'b1;
								occ_cmd.cnt_dec = 1'b1;
							end
						end
					end
					sst_pkg::OP_FIND: begin
						// issue the first slot of the walk
						res_load   = 1'b0;
						ram_en     = 1'b1;
						find_start = 1'b1;
					end
					sst_pkg::OP_CLEAR: begin
						occ_cmd.clear_all = 1'b1;
					end
					default: begin
					end
				endcase
			end
			sst_pkg::S_FIND: begin
				occ_q_addr = cmp_addr_s1;
				if (hit) begin
					res_load   = 1'b1;
					res_slot_d = 8'(cmp_addr_s1);
				end else if (walk_end) begin
					res_load     = 1'b1;
					res_status_d = sst_pkg::ST_EMPTY;
				end else begin
					// advance to the next slot
					find_step = 1'b1;
					ram_en    = 1'b1;
					ram_addr  = ptr_q[IDX_W-1:0];
				end
			end
			sst_pkg::S_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sst_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_accept) begin
			op_q  <= operation;
			idx_q <= slot_index;
			val_q <= ENTRY_WIDTH'(value_in);
		end
		if (res_load) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
			res_rd_q     <= res_rd_d;
		end
		if (find_start) begin
			ptr_q       <= PTR_W'(1);
			cmp_addr_s1 <= '0;
		end else if (find_step) begin
			ptr_q       <= ptr_q + PTR_W'(1);
			cmp_addr_s1 <= ptr_q[IDX_W-1:0];
		end
		if (out_load) begin
			value_out_q <= res_rd_q ? 32'(ram_rdata) : '0;
			slot_out_q  <= res_slot_q;
			status_q    <= res_status_q;
			count_out_q <= 9'(occ_count);
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign value_out      = value_out_q;
	assign slot_out       = slot_out_q;
	assign status         = status_q;
	assign occupied_count = count_out_q;

endmodule
`default_nettype wire
